// ----- rtl/lfrc_pkg.sv -----
// Shared types and constants for the length-prefixed frame receiver.
package lfrc_pkg;

  localparam int unsigned CountW = 9;

  // A length byte of zero stands for the largest payload.
  localparam logic [CountW-1:0] MaxPayload = 9'd256;
  localparam logic [CountW-1:0] MaxFrameLenReset = 9'd260;
  // Header, length, checksum and footer bytes around the payload.
  localparam logic [CountW-1:0] FrameOverhead = 9'd4;
  localparam logic [CountW-1:0] MinFrameLen = 9'd5;
  localparam logic [CountW-1:0] LengthPos = 9'd1;
  localparam logic [CountW-1:0] PayloadStart = 9'd2;

  typedef enum logic [1:0] {
    StInProgress = 2'd0,
    StGood       = 2'd1,
    StMismatch   = 2'd2,
    StOverflow   = 2'd3
  } status_e;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       is_payload;
    logic [7:0] payload_index;
    status_e    status;
  } result_t;

endpackage

// ----- rtl/lfrc_parser.sv -----
// Frame parse state and the per-byte result logic.
module lfrc_parser (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         accept_i,
  input  logic [7:0]                   rx_byte_i,
  input  logic [lfrc_pkg::CountW-1:0]  max_frame_len_i,
  output lfrc_pkg::result_t            result_o
);

  logic [lfrc_pkg::CountW-1:0] byte_count_q, byte_count_d;
  logic [lfrc_pkg::CountW-1:0] payload_length_q, payload_length_d;
  logic [7:0]                  running_sum_q, running_sum_d;
  logic [7:0]                  received_check_q, received_check_d;

  logic [lfrc_pkg::CountW-1:0] count_inc;
  logic [lfrc_pkg::CountW-1:0] offset;
  logic                        overflow;

  always_comb begin
    byte_count_d     = byte_count_q;
    payload_length_d = payload_length_q;
    running_sum_d    = running_sum_q;
    received_check_d = received_check_q;
    overflow         = (byte_count_q >= max_frame_len_i);
    count_inc        = byte_count_q + 9'd1;
    offset           = byte_count_q - lfrc_pkg::PayloadStart;

    result_o.data_byte     = rx_byte_i;
    result_o.is_payload    = 1'b0;
    result_o.payload_index = 8'd0;
    result_o.status        = lfrc_pkg::StInProgress;

    if (overflow) begin
      byte_count_d    = '0;
      result_o.status = lfrc_pkg::StOverflow;
    end else begin
      byte_count_d = count_inc;
      if (byte_count_q == lfrc_pkg::LengthPos) begin
        payload_length_d = (rx_byte_i == 8'd0) ? lfrc_pkg::MaxPayload : {1'b0, rx_byte_i};
        running_sum_d    = 8'd0 - payload_length_d[7:0];
      end else if (byte_count_q >= lfrc_pkg::PayloadStart) begin
        if (offset < payload_length_q) begin
          running_sum_d          = running_sum_q - rx_byte_i;
          result_o.is_payload    = 1'b1;
          result_o.payload_index = offset[7:0];
        end else if (offset == payload_length_q) begin
          received_check_d = rx_byte_i;
        end
      end
      // The footer byte closes the frame; judge the checksum on the updated values.
      if (count_inc >= lfrc_pkg::MinFrameLen &&
          count_inc == payload_length_d + lfrc_pkg::FrameOverhead) begin
        result_o.status = (running_sum_d == received_check_d) ? lfrc_pkg::StGood
                                                              : lfrc_pkg::StMismatch;
        byte_count_d    = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_count_q     <= '0;
      payload_length_q <= '0;
      running_sum_q    <= '0;
      received_check_q <= '0;
    end else if (accept_i) begin
      byte_count_q     <= byte_count_d;
      payload_length_q <= payload_length_d;
      running_sum_q    <= running_sum_d;
      received_check_q <= received_check_d;
    end
  end

endmodule

// ----- rtl/length_frame_receiver_checksum.sv -----
// Top level of the length-prefixed frame receiver with checksum.
//
//   channel | direction | handshake             | payload
//   --------+-----------+-----------------------+-------------------------------------
//   in      | sink      | in_valid_i/in_stall_o | rx_byte_i
//   out     | source    | out_valid_o/out_stall_i | data_byte_o, is_payload_o,
//           |           |                       | payload_index_o, status_o
//   cfg     | sink      | cfg_we_i              | cfg_wdata_i (max_frame_len)
//
// One beat per cycle while the output is not stalled; each result is registered before it leaves.
// The parse state updates in the same cycle a byte is taken, so bytes chain with no gap.
// Reset clears the parse state and sets the maximum frame length to 260.
// A stalled output holds its beat while one more byte lands in a skid register;
// the input stalls only while that skid register is full.
module length_frame_receiver_checksum (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [7:0]                  rx_byte_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [7:0]                  data_byte_o,
  output logic                        is_payload_o,
  output logic [7:0]                  payload_index_o,
  output logic [1:0]                  status_o,
  input  logic                        cfg_we_i,
  input  logic [lfrc_pkg::CountW-1:0] cfg_wdata_i
);

  logic [lfrc_pkg::CountW-1:0] max_frame_len_q;
  logic                        accept;
  logic                        out_free;
  lfrc_pkg::result_t           result;
  lfrc_pkg::result_t           out_q, skid_q;
  logic                        out_valid_q, skid_valid_q;

  assign accept   = in_valid_i && !skid_valid_q;
  assign out_free = !out_valid_q || !out_stall_i;

  lfrc_parser u_parser (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .accept_i        (accept),
    .rx_byte_i       (rx_byte_i),
    .max_frame_len_i (max_frame_len_q),
    .result_o        (result)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_frame_len_q <= lfrc_pkg::MaxFrameLenReset;
    end else if (cfg_we_i) begin
      max_frame_len_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (out_free) begin
      if (skid_valid_q) begin
        out_valid_q  <= 1'b1;
        skid_valid_q <= 1'b0;
      end else begin
        out_valid_q <= accept;
      end
    end else if (accept) begin
      skid_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free) begin
      if (skid_valid_q) begin
        out_q <= skid_q;
      end else if (accept) begin
        out_q <= result;
      end
    end else if (accept) begin
      skid_q <= result;
    end
  end

  assign in_stall_o      = skid_valid_q;
  assign out_valid_o     = out_valid_q;
  assign data_byte_o     = out_q.data_byte;
  assign is_payload_o    = out_q.is_payload;
  assign payload_index_o = out_q.payload_index;
  assign status_o        = out_q.status;

  // The skid register only fills behind a held output beat.
  assert property (@(posedge clk_i) disable iff (!rst_ni) skid_valid_q |-> out_valid_q)
    else $error("skid register holds a beat while the output is empty");

  // Payload bytes never close or abort a frame.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
      out_valid_q && out_q.is_payload |-> out_q.status == lfrc_pkg::StInProgress)
    else $error("payload byte reported a frame status");

  // Bytes outside the payload carry a zero index.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
      out_valid_q && !out_q.is_payload |-> out_q.payload_index == 8'd0)
    else $error("nonzero payload index outside the payload");

endmodule
